/* hw/rtl/thsup_pkg.sv */
package thsup_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_OP_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_OP_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEATER_ON_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCHOFF_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCES_PRESENT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TARGET   = 3'd6;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_SET    = 2'd1;
  localparam logic [1:0] KIND_IGNORE = 2'd2;

  localparam logic [1:0] TGT_HEATING = 2'd0;
  localparam logic [1:0] TGT_OP      = 2'd1;
  localparam logic [1:0] TGT_IGNORE  = 2'd2;

  localparam logic [2:0] NT_IGNORE   = 3'd2;
  localparam logic [2:0] NT_LAST_OK  = 3'd2;

  localparam logic [1:0] SET_OK      = 2'd0;
  localparam logic [1:0] SET_REFUSED = 2'd1;
  localparam logic [1:0] SET_INVALID = 2'd2;

  localparam logic [1:0] REQ_NONE    = 2'd0;
  localparam logic [1:0] REQ_ON      = 2'd1;
  localparam logic [1:0] REQ_OFF     = 2'd2;

  localparam logic [2:0] CS_UNKNOWN  = 3'd0;
  localparam logic [2:0] CS_LOW      = 3'd1;
  localparam logic [2:0] CS_OP       = 3'd2;
  localparam logic [2:0] CS_HIGH     = 3'd3;
  localparam logic [2:0] CS_LOW_IGN  = 3'd4;
  localparam logic [2:0] CS_OP_IGN   = 3'd5;
  localparam logic [2:0] CS_HIGH_IGN = 3'd6;

  localparam logic [2:0] CS_IGN_OFFSET = 3'd3;

  typedef struct packed {
    logic [CFG_W-1:0] lower_op_limit;
    logic [CFG_W-1:0] upper_op_limit;
    logic [CFG_W-1:0] heater_on_margin;
    logic [CFG_W-1:0] hysteresis;
    logic [CFG_W-1:0] switchoff_margin;
    logic [3:0]       sources_present;
    logic [1:0]       initial_target;
  } cfg_t;

  function automatic logic [2:0] ignored_of(input logic [2:0] s);
    logic [2:0] r;
    case (s) inside
      [CS_LOW:CS_HIGH]:         r = s + CS_IGN_OFFSET;
      [CS_LOW_IGN:CS_HIGH_IGN]: r = s;
      default:                  r = CS_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/thsup_cfg.sv */
module thsup_cfg (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [thsup_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [thsup_pkg::CFG_W-1:0]            cfg_data,
  output thsup_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_op_limit   <= 16'sd0;
      cfg.upper_op_limit   <= 16'd640;
      cfg.heater_on_margin <= 16'd16;
      cfg.hysteresis       <= 16'd16;
      cfg.switchoff_margin <= 16'd16;
      cfg.sources_present  <= 4'hf;
      cfg.initial_target   <= thsup_pkg::TGT_OP;
    end else if (cfg_valid) begin
      case (cfg_index)
        thsup_pkg::CFG_LOWER_OP_LIMIT:   cfg.lower_op_limit   <= cfg_data;
        thsup_pkg::CFG_UPPER_OP_LIMIT:   cfg.upper_op_limit   <= cfg_data;
        thsup_pkg::CFG_HEATER_ON_MARGIN: cfg.heater_on_margin <= cfg_data;
        thsup_pkg::CFG_HYSTERESIS:       cfg.hysteresis       <= cfg_data;
        thsup_pkg::CFG_SWITCHOFF_MARGIN: cfg.switchoff_margin <= cfg_data;
        thsup_pkg::CFG_SOURCES_PRESENT:  cfg.sources_present  <= cfg_data[3:0];
        thsup_pkg::CFG_INITIAL_TARGET:   cfg.initial_target   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/thsup_core.sv */
module thsup_core #(
  parameter int TEMP_WIDTH = 16,
  localparam int SrcW = TEMP_WIDTH + 1,
  localparam int ItemW = 4 * SrcW + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [1:0]                   kind,
  input  logic [ItemW-1:0]             item,
  input  thsup_pkg::cfg_t              cfg,
  output logic [TEMP_WIDTH-1:0]        selected_temp,
  output logic                         temp_valid,
  output logic [2:0]                   component_state,
  output logic [1:0]                   heater_request,
  output logic [1:0]                   target_now,
  output logic [1:0]                   set_status,
  output logic [TEMP_WIDTH-1:0]        min_seen,
  output logic [TEMP_WIDTH-1:0]        max_seen
);

  localparam int TW = TEMP_WIDTH;
  localparam int CW = (TW > thsup_pkg::CFG_W) ? TW : thsup_pkg::CFG_W;

  function automatic logic [TW-1:0] lim_of(input logic [thsup_pkg::CFG_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return e[TW-1:0];
  endfunction

  logic                 heating, heating_next;
  logic [1:0]           target_code, target_code_next;
  logic                 overridden, overridden_next;
  logic [2:0]           state_code, state_code_next;
  logic [1:0]           request_code, request_code_next;
  logic [TW-1:0]        last_temp, last_temp_next;
  logic                 last_valid, last_valid_next;
  logic [TW-1:0]        min_temp, min_temp_next;
  logic [TW-1:0]        max_temp, max_temp_next;
  logic [1:0]           status, status_next;

  logic                 found;
  logic signed [TW-1:0] t, lo, hi, hom, hys, swm;
  logic signed [TW:0]   off_th;
  logic signed [TW+1:0] on_th, t_x;
  logic [1:0]           tgt;
  logic [2:0]           cls;
  logic [2:0]           nt;

  assign tgt = overridden ? target_code : cfg.initial_target;
  assign nt  = item[4*SrcW +: 3];
  assign lo  = lim_of(cfg.lower_op_limit);
  assign hi  = lim_of(cfg.upper_op_limit);
  assign hom = lim_of(cfg.heater_on_margin);
  assign hys = lim_of(cfg.hysteresis);
  assign swm = lim_of(cfg.switchoff_margin);

  always_comb begin
    found = 1'b0;
    t     = '0;
    for (int i = 3; i >= 0; i--) begin
      if (cfg.sources_present[i] && item[i*SrcW + TW]) begin
        found = 1'b1;
        t     = item[i*SrcW +: TW];
      end
    end
  end

  assign t_x    = $signed({{2{t[TW-1]}}, t});
  assign off_th = $signed({hi[TW-1], hi}) - $signed({swm[TW-1], swm});
  assign on_th  = $signed({{2{lo[TW-1]}}, lo}) + $signed({{2{hom[TW-1]}}, hom})
                + (heating ? $signed({{2{hys[TW-1]}}, hys}) : $signed((TW+2)'(0)));

  always_comb begin
    if (t < lo) begin
      cls = thsup_pkg::CS_LOW;
    end else if (t < hi) begin
      cls = thsup_pkg::CS_OP;
    end else begin
      cls = thsup_pkg::CS_HIGH;
    end
  end

  always_comb begin
    heating_next      = heating;
    target_code_next  = target_code;
    overridden_next   = overridden;
    state_code_next   = state_code;
    request_code_next = request_code;
    last_temp_next    = last_temp;
    last_valid_next   = last_valid;
    min_temp_next     = min_temp;
    max_temp_next     = max_temp;
    status_next       = thsup_pkg::SET_OK;
    case (kind)
      thsup_pkg::KIND_SAMPLE: begin
        if (!found) begin
          last_temp_next    = '0;
          last_valid_next   = 1'b0;
          state_code_next   = thsup_pkg::CS_UNKNOWN;
          request_code_next = thsup_pkg::REQ_NONE;
        end else begin
          last_temp_next  = t;
          last_valid_next = 1'b1;
          if (t < $signed(min_temp)) min_temp_next = t;
          if (t > $signed(max_temp)) max_temp_next = t;
          if (tgt == thsup_pkg::TGT_IGNORE) begin
            state_code_next   = thsup_pkg::ignored_of(cls);
            heating_next      = 1'b0;
            request_code_next = thsup_pkg::REQ_NONE;
          end else begin
            state_code_next = cls;
            if ($signed({t[TW-1], t}) > off_th) begin
              heating_next      = 1'b0;
              request_code_next = thsup_pkg::REQ_OFF;
            end else if (t_x < on_th) begin
              heating_next      = 1'b1;
              request_code_next = thsup_pkg::REQ_ON;
            end else begin
              heating_next      = 1'b0;
              request_code_next = thsup_pkg::REQ_NONE;
            end
          end
        end
      end
      thsup_pkg::KIND_SET: begin
        if (tgt == thsup_pkg::TGT_OP && nt != thsup_pkg::NT_IGNORE) begin
          status_next = thsup_pkg::SET_REFUSED;
        end else if (nt > thsup_pkg::NT_LAST_OK) begin
          status_next = thsup_pkg::SET_INVALID;
        end else begin
          target_code_next = nt[1:0];
          overridden_next  = 1'b1;
        end
      end
      thsup_pkg::KIND_IGNORE: begin
        state_code_next = thsup_pkg::ignored_of(state_code);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heating      <= 1'b0;
      target_code  <= thsup_pkg::TGT_HEATING;
      overridden   <= 1'b0;
      state_code   <= thsup_pkg::CS_UNKNOWN;
      request_code <= thsup_pkg::REQ_NONE;
      last_temp    <= '0;
      last_valid   <= 1'b0;
      min_temp     <= {1'b0, {(TW-1){1'b1}}};
      max_temp     <= {1'b1, {(TW-1){1'b0}}};
      status       <= thsup_pkg::SET_OK;
    end else if (adv) begin
      heating      <= heating_next;
      target_code  <= target_code_next;
      overridden   <= overridden_next;
      state_code   <= state_code_next;
      request_code <= request_code_next;
      last_temp    <= last_temp_next;
      last_valid   <= last_valid_next;
      min_temp     <= min_temp_next;
      max_temp     <= max_temp_next;
      status       <= status_next;
    end
  end

  assign selected_temp   = last_temp;
  assign temp_valid      = last_valid;
  assign component_state = state_code;
  assign heater_request  = request_code;
  assign target_now      = tgt;
  assign set_status      = status;
  assign min_seen        = min_temp;
  assign max_seen        = max_temp;

endmodule

/* hw/rtl/thermal_component_heater_supervisor_top.sv */
// Heater supervisor for one heated component.
// Input stream (s_axis_*): one item per transfer. tuser carries the item kind
// (sample, set target, mark ignored); tdata carries four readings with their
// valid flags and the requested target.
// Output stream (m_axis_*): exactly one result per input item, in order.
// Configuration channel (cfg_*): one register write per transfer, always ready;
// write only while no item is in flight. Indexes past the last register drop.
// Path: an accepted item waits in the input register until the result register
// is free or being taken, then its result is registered and offered on m_axis.
// Throughput: one item per cycle while m_axis_tready is high; all work is a priority
// select, a few extended-width adds and compares between input and result registers.
// Stall: when m_axis_tready is low the result holds and the input register
// keeps one more item; s_axis_tready drops only when both are occupied.
// Reset (rst, synchronous): configuration returns to its defaults, state goes
// to unknown with no heater request, min/max tracking restarts, no valids.
module thermal_component_heater_supervisor_top #(
  parameter int TEMP_WIDTH = 16,
  localparam int SrcW = TEMP_WIDTH + 1,
  localparam int ItemW = 4 * SrcW + 3,
  localparam int InW = ((ItemW + 7) / 8) * 8,
  localparam int ResW = 3 * TEMP_WIDTH + 10,
  localparam int OutW = ((ResW + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // primary_temp, primary_valid, backup1_temp, backup1_valid, backup2_temp,
  // backup2_valid, module_temp, module_valid, new_target, zero fill
  input  logic [InW-1:0]                      s_axis_tdata,
  // kind
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // selected_temp, temp_valid, component_state, heater_request, target_now,
  // set_status, min_seen, max_seen, zero fill
  output logic [OutW-1:0]                     m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [thsup_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [thsup_pkg::CFG_W-1:0]         cfg_data
);

  thsup_pkg::cfg_t cfg;

  logic                  in_vld;
  logic [ItemW-1:0]      in_item;
  logic [1:0]            in_kind;
  logic                  out_vld;
  logic                  adv;

  logic [TEMP_WIDTH-1:0] selected_temp;
  logic                  temp_valid;
  logic [2:0]            component_state;
  logic [1:0]            heater_request;
  logic [1:0]            target_now;
  logic [1:0]            set_status;
  logic [TEMP_WIDTH-1:0] min_seen;
  logic [TEMP_WIDTH-1:0] max_seen;

  assign cfg_ready     = 1'b1;
  assign adv           = in_vld && (!out_vld || m_axis_tready);
  assign s_axis_tready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld <= s_axis_tvalid;
      if (adv) begin
        out_vld <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= s_axis_tdata[ItemW-1:0];
      in_kind <= s_axis_tuser;
    end
  end

  thsup_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  thsup_core #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .kind            (in_kind),
    .item            (in_item),
    .cfg             (cfg),
    .selected_temp   (selected_temp),
    .temp_valid      (temp_valid),
    .component_state (component_state),
    .heater_request  (heater_request),
    .target_now      (target_now),
    .set_status      (set_status),
    .min_seen        (min_seen),
    .max_seen        (max_seen)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = OutW'({max_seen, min_seen, set_status, target_now,
                                heater_request, component_state, temp_valid,
                                selected_temp});

endmodule
